>>> rtl/core/dqsp_pkg.sv
// dqsp_pkg: shared types and constants for the dns question section parser
// no dependencies; used by dqsp_step and dns_question_section_parser_unit

package dqsp_pkg;

    // parse phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b000_0001,
        PH_LENGTH   = 7'b000_0010,
        PH_LABEL    = 7'b000_0100,
        PH_TYPE_HI  = 7'b000_1000,
        PH_TYPE_LO  = 7'b001_0000,
        PH_CLASS_HI = 7'b010_0000,
        PH_CLASS_LO = 7'b100_0000
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // request modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    // lengths at or above this are pointers or reserved codes
    localparam logic [7:0] LABEL_LIMIT = 8'd64;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  label_left;
        logic        name_begun;
        logic [15:0] questions_left;
        logic [15:0] current_index;
        logic [15:0] type_hold;
        logic [7:0]  class_high;
    } parse_state_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  name_char;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [15:0] question_index;
        logic        last_question;
    } parse_result_t;

endpackage

>>> rtl/core/dqsp_step.sv
// dqsp_step: next parser state and optional result for one request
// depends on dqsp_pkg

module dqsp_step (
    input  dqsp_pkg::parse_state_t  cur_state,
    input  logic                    mode,
    input  logic [15:0]             question_count,
    input  logic [7:0]              data_byte,
    output dqsp_pkg::parse_state_t  nxt_state,
    output dqsp_pkg::parse_result_t result
);

    logic [5:0] label_dec;

    assign label_dec = cur_state.label_left - 6'd1;

    always_comb begin
        nxt_state              = cur_state;
        result.valid           = 1'b0;
        result.kind            = dqsp_pkg::KIND_CHAR;
        result.name_char       = 8'd0;
        result.query_type      = 16'd0;
        result.query_class     = 16'd0;
        result.question_index  = cur_state.current_index;
        result.last_question   = (cur_state.questions_left == 16'd1);

        if (mode == dqsp_pkg::MODE_START) begin
            nxt_state.questions_left = question_count;
            nxt_state.current_index  = 16'd0;
            nxt_state.label_left     = 6'd0;
            nxt_state.name_begun     = 1'b0;
            nxt_state.type_hold      = 16'd0;
            nxt_state.class_high     = 8'd0;
            nxt_state.phase          = (question_count != 16'd0) ? dqsp_pkg::PH_LENGTH
                                                                 : dqsp_pkg::PH_IDLE;
        end else begin
            unique case (cur_state.phase)
                dqsp_pkg::PH_LENGTH: begin
                    priority if (data_byte == 8'd0) begin
                        result.valid    = 1'b1;
                        result.kind     = dqsp_pkg::KIND_END;
                        nxt_state.phase = dqsp_pkg::PH_TYPE_HI;
                    end else if (data_byte >= dqsp_pkg::LABEL_LIMIT) begin
                        result.valid    = 1'b1;
                        result.kind     = dqsp_pkg::KIND_ERROR;
                        nxt_state.phase = dqsp_pkg::PH_IDLE;
                    end else begin
                        nxt_state.label_left = data_byte[5:0];
                        nxt_state.phase      = dqsp_pkg::PH_LABEL;
                        nxt_state.name_begun = 1'b1;
                        if (cur_state.name_begun) begin
                            result.valid     = 1'b1;
                            result.kind      = dqsp_pkg::KIND_CHAR;
                            result.name_char = dqsp_pkg::DOT_CHAR;
                        end
                    end
                end
                dqsp_pkg::PH_LABEL: begin
                    result.valid         = 1'b1;
                    result.kind          = dqsp_pkg::KIND_CHAR;
                    result.name_char     = data_byte;
                    nxt_state.label_left = label_dec;
                    if (label_dec == 6'd0) begin
                        nxt_state.phase = dqsp_pkg::PH_LENGTH;
                    end
                end
                dqsp_pkg::PH_TYPE_HI: begin
                    nxt_state.type_hold = {data_byte, 8'd0};
                    nxt_state.phase     = dqsp_pkg::PH_TYPE_LO;
                end
                dqsp_pkg::PH_TYPE_LO: begin
                    nxt_state.type_hold = {cur_state.type_hold[15:8], data_byte};
                    nxt_state.phase     = dqsp_pkg::PH_CLASS_HI;
                end
                dqsp_pkg::PH_CLASS_HI: begin
                    nxt_state.class_high = data_byte;
                    nxt_state.phase      = dqsp_pkg::PH_CLASS_LO;
                end
                dqsp_pkg::PH_CLASS_LO: begin
                    result.valid             = 1'b1;
                    result.kind              = dqsp_pkg::KIND_DONE;
                    result.query_type        = cur_state.type_hold;
                    result.query_class       = {cur_state.class_high, data_byte};
                    nxt_state.questions_left = cur_state.questions_left - 16'd1;
                    nxt_state.current_index  = cur_state.current_index + 16'd1;
                    nxt_state.name_begun     = 1'b0;
                    nxt_state.phase = (cur_state.questions_left == 16'd1)
                                      ? dqsp_pkg::PH_IDLE : dqsp_pkg::PH_LENGTH;
                end
                default: begin
                    // idle: data is dropped
                    nxt_state = cur_state;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/dns_question_section_parser_unit.sv
// dns_question_section_parser_unit: top level of the dns question section parser
// depends on dqsp_pkg and dqsp_step

// The parser takes one request per cycle while nothing is stalled: either a start
// (mode 0) that loads the question count, or one raw byte of the question section
// (mode 1). Each byte passes through an input register, then a single stage of
// decode logic that updates the parse state and writes at most one result into
// the output register. Sustained rate is one byte per clock while m_ready keeps
// up; a result is held in the output register once its request has left the
// input register and been decoded. The only limit is the output register, which
// holds a result until m_ready takes it, so backpressure stalls the input
// register and then s_ready. Results are name characters (a dot goes before
// every label but the first), a name end on the zero byte, a question done
// carrying type and class on the last class byte, or an error for a length
// byte of 64 or more, after which further data is ignored until a new start.
// Start requests, the length byte of the first label and bytes of type and high
// class never give a result.

module dns_question_section_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_question_count,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_name_char,
    output logic [15:0] m_query_type,
    output logic [15:0] m_query_class,
    output logic [15:0] m_question_index,
    output logic        m_last_question
);

    // input register
    logic        in_valid_reg;
    logic        in_mode_reg;
    logic [15:0] in_count_reg;
    logic [7:0]  in_data_reg;

    // parse state
    dqsp_pkg::parse_state_t  state_reg;
    dqsp_pkg::parse_state_t  state_next;

    // result register
    logic                    out_valid_reg;
    dqsp_pkg::parse_result_t out_reg;
    dqsp_pkg::parse_result_t out_next;

    logic advance;
    logic s_take;

    // the held request is processed when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    dqsp_step u_step (
        .cur_state      (state_reg),
        .mode           (in_mode_reg),
        .question_count (in_count_reg),
        .data_byte      (in_data_reg),
        .nxt_state      (state_next),
        .result         (out_next)
    );

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_mode_reg  <= s_mode;
            in_count_reg <= s_question_count;
            in_data_reg  <= s_data_byte;
        end
    end

    // parse state advances once per processed request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= dqsp_pkg::PH_IDLE;
            state_reg.label_left     <= 6'd0;
            state_reg.name_begun     <= 1'b0;
            state_reg.questions_left <= 16'd0;
            state_reg.current_index  <= 16'd0;
            state_reg.type_hold      <= 16'd0;
            state_reg.class_high     <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result valid: loaded on processing, cleared once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= out_next.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && out_next.valid) begin
            out_reg <= out_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_name_char      = out_reg.name_char;
    assign m_query_type     = out_reg.query_type;
    assign m_query_class    = out_reg.query_class;
    assign m_question_index = out_reg.question_index;
    assign m_last_question  = out_reg.last_question;

endmodule

>>> dv/question_parse_checker.sv
// question_parse_checker: watches both channels of the dns question section parser,
// predicts every result from the accepted requests and compares them in order
// depends on dqsp_pkg

module question_parse_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_question_count,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [7:0]  m_name_char,
    input  logic [15:0] m_query_type,
    input  logic [15:0] m_query_class,
    input  logic [15:0] m_question_index,
    input  logic        m_last_question,
    output int          mismatch_count,
    output int          results_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        dqsp_pkg::kind_t kind;
        logic [7:0]      name_char;
        logic [15:0]     query_type;
        logic [15:0]     query_class;
        logic [15:0]     question_index;
        logic            last_question;
    } name_result_t;

    name_result_t awaited_results[$];
    int           mismatch_total = 0;

    // predicted parse state
    dqsp_pkg::phase_t parse_phase;
    logic [5:0]       label_left;
    logic             name_begun;
    logic [15:0]      questions_left;
    logic [15:0]      question_index;
    logic [15:0]      type_hold;
    logic [7:0]       class_high;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_total++;
    endtask

    task automatic queue_result(input dqsp_pkg::kind_t kind, input logic [7:0] ch,
                                input logic [15:0] qtype, input logic [15:0] qclass);
        name_result_t r;
        r.kind           = kind;
        r.name_char      = ch;
        r.query_type     = qtype;
        r.query_class    = qclass;
        r.question_index = question_index;
        r.last_question  = (questions_left == 16'd1);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    task automatic clear_parse_state();
        parse_phase    = dqsp_pkg::PH_IDLE;
        label_left     = '0;
        name_begun     = 1'b0;
        questions_left = '0;
        question_index = '0;
        type_hold      = '0;
        class_high     = '0;
    endtask

    task automatic parse_request(input logic mode, input logic [15:0] count,
                                 input logic [7:0] data_val);
        if (mode == dqsp_pkg::MODE_START) begin
            // a start drops whatever section was in progress
            clear_parse_state();
            questions_left = count;
            parse_phase    = (count != 16'd0) ? dqsp_pkg::PH_LENGTH : dqsp_pkg::PH_IDLE;
        end else begin
            case (parse_phase)
                dqsp_pkg::PH_LENGTH: begin
                    if (data_val == 8'd0) begin
                        queue_result(dqsp_pkg::KIND_END, 8'd0, 16'd0, 16'd0);
                        parse_phase = dqsp_pkg::PH_TYPE_HI;
                    end else if (data_val >= dqsp_pkg::LABEL_LIMIT) begin
                        queue_result(dqsp_pkg::KIND_ERROR, 8'd0, 16'd0, 16'd0);
                        parse_phase = dqsp_pkg::PH_IDLE;
                    end else begin
                        label_left  = data_val[5:0];
                        parse_phase = dqsp_pkg::PH_LABEL;
                        if (name_begun) begin
                            queue_result(dqsp_pkg::KIND_CHAR, dqsp_pkg::DOT_CHAR,
                                         16'd0, 16'd0);
                        end
                        name_begun = 1'b1;
                    end
                end
                dqsp_pkg::PH_LABEL: begin
                    queue_result(dqsp_pkg::KIND_CHAR, data_val, 16'd0, 16'd0);
                    label_left = label_left - 6'd1;
                    if (label_left == 6'd0) begin
                        parse_phase = dqsp_pkg::PH_LENGTH;
                    end
                end
                dqsp_pkg::PH_TYPE_HI: begin
                    type_hold   = {data_val, 8'h00};
                    parse_phase = dqsp_pkg::PH_TYPE_LO;
                end
                dqsp_pkg::PH_TYPE_LO: begin
                    type_hold   = type_hold | {8'h00, data_val};
                    parse_phase = dqsp_pkg::PH_CLASS_HI;
                end
                dqsp_pkg::PH_CLASS_HI: begin
                    class_high  = data_val;
                    parse_phase = dqsp_pkg::PH_CLASS_LO;
                end
                dqsp_pkg::PH_CLASS_LO: begin
                    queue_result(dqsp_pkg::KIND_DONE, 8'd0, type_hold,
                                 {class_high, data_val});
                    questions_left = questions_left - 16'd1;
                    question_index = question_index + 16'd1;
                    name_begun     = 1'b0;
                    parse_phase    = (questions_left == 16'd0) ? dqsp_pkg::PH_IDLE
                                                               : dqsp_pkg::PH_LENGTH;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want, input logic [15:0] idx);
        if (got !== want) begin
            report_mismatch($sformatf("question %0d %s got %h want %h", idx, field, got, want));
        end
    endtask

    task automatic check_result();
        name_result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d with none expected", m_kind));
        end else begin
            want = awaited_results.pop_front();
            check_field("kind", 16'(m_kind), 16'(want.kind), want.question_index);
            check_field("name_char", 16'(m_name_char), 16'(want.name_char),
                        want.question_index);
            check_field("query_type", m_query_type, want.query_type, want.question_index);
            check_field("query_class", m_query_class, want.query_class, want.question_index);
            check_field("question_index", m_question_index, want.question_index,
                        want.question_index);
            check_field("last_question", 16'(m_last_question), 16'(want.last_question),
                        want.question_index);
        end
    endtask

    // results leave only after their request has passed the input and result registers, so checking first is safe
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse_state();
            awaited_results.delete();
            results_waiting <= 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                parse_request(s_mode, s_question_count, s_data_byte);
            end
            results_waiting <= awaited_results.size();
        end
        mismatch_count <= mismatch_total;
    end

endmodule

>>> dv/tb.sv
// tb: top of the dns question section parser testbench; drives requests, stalls
// the result channel and gives the verdict
// depends on dqsp_pkg, dns_question_section_parser_unit and question_parse_checker

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 1650;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_IDLE        = 12;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_mode           = dqsp_pkg::MODE_DATA;
    logic [15:0] s_question_count = '0;
    logic [7:0]  s_data_byte      = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_name_char;
    logic [15:0] m_query_type;
    logic [15:0] m_query_class;
    logic [15:0] m_question_index;
    logic        m_last_question;

    int mismatch_count;
    int results_waiting;

    // requests that the parser acts on; ignored noise does not count
    int parse_requests = 0;

    // gaps on either side come and go in stretches
    bit source_gaps = 1'b1;
    bit sink_gaps   = 1'b1;

    always #6 aclk = ~aclk;

    dns_question_section_parser_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_question_count (s_question_count),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_name_char      (m_name_char),
        .m_query_type     (m_query_type),
        .m_query_class    (m_query_class),
        .m_question_index (m_question_index),
        .m_last_question  (m_last_question)
    );

    question_parse_checker result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_question_count (s_question_count),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_name_char      (m_name_char),
        .m_query_type     (m_query_type),
        .m_query_class    (m_query_class),
        .m_question_index (m_question_index),
        .m_last_question  (m_last_question),
        .mismatch_count   (mismatch_count),
        .results_waiting  (results_waiting)
    );

    // one request on the input channel; called at a rising edge, returns at the
    // edge where the request is taken. valid only drops when a gap is drawn, so
    // back-to-back requests keep it high with a single assignment per edge
    task automatic send_request(input logic mode, input logic [15:0] count,
                                input logic [7:0] data_val);
        int gap;
        if ($urandom_range(0, 99) == 0) begin
            source_gaps = ~source_gaps;
        end
        gap = source_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_question_count <= count;
        s_data_byte      <= data_val;
        // ready is read before this edge's updates land, i.e. as the parser sees it
        do @(posedge aclk); while (!s_ready);
    endtask

    // start carries a random byte that must be ignored
    task automatic send_start(input logic [15:0] count);
        send_request(dqsp_pkg::MODE_START, count, 8'($urandom()));
        parse_requests++;
    endtask

    // data carries a random question count that must be ignored
    task automatic send_byte(input logic [7:0] data_val);
        send_request(dqsp_pkg::MODE_DATA, 16'($urandom()), data_val);
        parse_requests++;
    endtask

    // stray bytes, usually landing while the parser is idle
    task automatic send_noise(input int n);
        repeat (n) send_request(dqsp_pkg::MODE_DATA, 16'($urandom()), 8'($urandom()));
    endtask

    // big-endian 16-bit field: query type or class
    task automatic send_field16(input logic [15:0] value);
        send_byte(value[15:8]);
        send_byte(value[7:0]);
    endtask

    // mostly short labels, now and then the longest legal one
    function automatic logic [7:0] pick_label_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            return 8'd63;
        end else if (roll < 12) begin
            return 8'($urandom_range(1, 63));
        end
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic logic [15:0] pick_field16();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 16'h0000;
        end else if (roll == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom());
    endfunction

    task automatic send_labels(input int n_labels);
        logic [7:0] len;
        repeat (n_labels) begin
            len = pick_label_length();
            send_byte(len);
            repeat (len) send_byte(8'($urandom()));
        end
    endtask

    // a complete question: name, zero byte, type and class
    task automatic send_question(input int n_labels);
        send_labels(n_labels);
        send_byte(8'd0);
        send_field16(pick_field16());
        send_field16(pick_field16());
    endtask

    // result channel: a fresh stall is drawn for every result
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 99) == 0) begin
                sink_gaps = ~sink_gaps;
            end
            stall = sink_gaps ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** dns_question_section_parser_unit: FAILED **");
        $finish;
    end

    initial begin
        int section_count;
        int n_questions;
        int roll;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // data straight after reset is ignored
        send_byte(8'hA5);
        // empty section stays idle, the following byte is ignored
        send_start(16'd0);
        send_byte(8'h00);

        // two questions: first has a zero byte inside a label and a dot-valued byte,
        // second is the root name; type and class at both extremes
        send_start(16'd2);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(dqsp_pkg::DOT_CHAR);
        send_byte(8'd0);
        send_field16(16'hFFFF);
        send_field16(16'h0000);
        send_byte(8'd0);
        send_field16(16'h0000);
        send_field16(16'hFFFF);
        // after the last question the byte is ignored
        send_byte(8'h7F);

        // lowest and highest pointer or reserved length, then data after the error
        send_start(16'd1);
        send_byte(dqsp_pkg::LABEL_LIMIT);
        send_byte(8'd3);
        send_start(16'd3);
        send_byte(8'hFF);

        // a start in mid label drops the section in progress
        send_start(16'hFFFF);
        send_byte(8'd1);
        send_start(16'd1);
        send_byte(8'hC0);

        // ---- random part ----
        while (parse_requests < TARGET_REQUESTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                section_count = 0;
            end else if (roll < 12) begin
                section_count = $urandom_range(0, 65535);
            end else begin
                section_count = $urandom_range(1, 4);
            end
            send_start(16'(section_count));

            // huge sections are cut short by the next start
            n_questions = (section_count > 4) ? $urandom_range(0, 3) : section_count;
            for (int q = 0; q < n_questions; q++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    // compression pointer where a length is due
                    send_labels($urandom_range(0, 2));
                    send_byte(8'($urandom_range(64, 255)));
                    break;
                end else if (roll < 10) begin
                    // name broken off mid label, dropped by the next start
                    send_labels($urandom_range(0, 1));
                    send_byte(8'($urandom_range(3, 63)));
                    send_byte(8'($urandom()));
                    break;
                end
                send_question($urandom_range(0, 4));
            end

            if ($urandom_range(0, 9) == 0) begin
                send_noise($urandom_range(1, 4));
            end
        end

        // ---- drain ----
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && results_waiting == 0) begin
            $display("** dns_question_section_parser_unit: PASSED **");
        end else begin
            $display("** dns_question_section_parser_unit: FAILED **");
        end
        $finish;
    end

endmodule
